FILE: hw/rtl/loco_predictor_residual_assert.svh
// Assertion macros for the LOCO predictor block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef LOCO_PREDICTOR_RESIDUAL_ASSERT_SVH
`define LOCO_PREDICTOR_RESIDUAL_ASSERT_SVH

// Condition must hold at every clock edge out of reset
`define LPR_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LPR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lpr_pkg.sv
// Shared types, constants and helper functions of the LOCO predictor.
// No dependencies.
package lpr_pkg;

  localparam int unsigned MaxWidth = 4096;
  localparam int unsigned NumCtx   = 365;
  localparam int unsigned CtxAw    = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // gradient thresholds
  localparam int T1 = 3;
  localparam int T2 = 7;
  localparam int T3 = 21;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode   = 2'd0,
    CfgWidth  = 2'd1,
    CfgHeight = 2'd2
  } cfg_idx_e;

  // one context entry
  typedef struct packed {
    logic [6:0]        count;
    logic signed [6:0] bias;
    logic signed [7:0] corr;
  } ctx_t;

  localparam ctx_t CtxInit = '{count: 7'd1, bias: 7'sd0, corr: 8'sd0};

  // 9-level gradient quantizer
  function automatic logic signed [3:0] quant9(input logic signed [9:0] g);
    logic signed [3:0] q;
    if (g <= -10'(T3))      q = -4'sd4;
    else if (g <= -10'(T2)) q = -4'sd3;
    else if (g <= -10'(T1)) q = -4'sd2;
    else if (g < 0)         q = -4'sd1;
    else if (g == 0)        q = 4'sd0;
    else if (g < 10'(T1))   q = 4'sd1;
    else if (g < 10'(T2))   q = 4'sd2;
    else if (g < 10'(T3))   q = 4'sd3;
    else                    q = 4'sd4;
    return q;
  endfunction

  // median edge detector
  function automatic logic [7:0] med(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] c);
    logic [7:0] mx;
    logic [7:0] mn;
    logic [9:0] s;
    mx = (a > b) ? a : b;
    mn = (a > b) ? b : a;
    s  = {2'b0, a} + {2'b0, b} - {2'b0, c};
    if (c >= mx)      return mn;
    else if (c <= mn) return mx;
    else              return s[7:0];
  endfunction

  // context index from normalized quantized gradients
  function automatic logic [CtxAw-1:0] ctx_index(input logic signed [3:0] q1,
                                                 input logic signed [3:0] q2,
                                                 input logic signed [3:0] q3);
    logic signed [10:0] k;
    k = 11'sd81 * 11'(q1) + 11'sd9 * 11'(q2) + 11'(q3);
    return k[CtxAw-1:0];
  endfunction

endpackage

FILE: hw/rtl/loco_predictor_residual.sv
// Top level of the LOCO-I context predictor (pixel <-> residual).
// Depends on lpr_pkg, lpr_ram and loco_predictor_residual_assert.svh.

// One word in gives one word out. From accept to result, each pixel goes
// through a position step, two line-store reads for the pixels above, one
// context-memory read, a prep step, a bit-serial divider for the
// bias correction, and a write-back. After reset, and on a word with
// start_of_image set, a clearing pass writes all 365 context entries before
// work goes on; words are not taken during the pass after reset, while
// register writes are. Register writes must only happen while the block is
// idle.
module loco_predictor_residual #(
  parameter int unsigned MAX_WIDTH = lpr_pkg::MaxWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // register write port
  input  logic                         cfg_we_i,
  input  logic [lpr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lpr_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,   // [7:0] sample_in
  input  logic                         s_axis_tuser,   // [0] start_of_image
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,   // [8:0] sample_out
  output logic                         m_axis_tlast    // last_of_image
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW = CW + 1;
  localparam int unsigned CA = lpr_pkg::CtxAw;

  typedef enum logic [8:0] {
    StClr  = 9'b000000001,
    StIdle = 9'b000000010,
    StPos  = 9'b000000100,
    StRdB  = 9'b000001000,
    StRdD  = 9'b000010000,
    StCtx  = 9'b000100000,
    StPrep = 9'b001000000,
    StDiv  = 9'b010000000,
    StWb   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic        mode_q;
  logic [12:0] width_q;
  logic [15:0] height_q;

  // position and neighbors
  logic [CW-1:0] col_q, col_d;
  logic [15:0]   row_q, row_d;
  logic [7:0]    left_q, left_d;
  logic [7:0]    upleft_q, upleft_d;

  // per-pixel work registers
  logic [7:0]          low8_q, low8_d;
  logic                clr_go_q, clr_go_d;
  logic [CA-1:0]       clr_cnt_q, clr_cnt_d;
  logic [7:0]          b_q, b_d;
  logic [7:0]          med_q, med_d;
  logic                sgn_q, sgn_d;
  logic [CA-1:0]       k_q, k_d;
  logic signed [7:0]   e_q, e_d;
  logic [7:0]          pix_q, pix_d;
  logic [6:0]          n_q, n_d;
  logic signed [6:0]   bias_q, bias_d;
  logic signed [9:0]   bs_q, bs_d;
  logic [6:0]          n1_q, n1_d;
  logic [8:0]          res_q, res_d;

  // divider
  logic [6:0] rem_q, rem_d;
  logic [7:0] quo_q, quo_d;
  logic [2:0] dcnt_q, dcnt_d;
  logic       neg_q, neg_d;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [8:0] out_q, out_d;
  logic       out_last_q, out_last_d;

  // memories
  logic                line_we;
  logic [CW-1:0]       line_waddr, line_raddr;
  logic [7:0]          line_rdata;
  logic                ctx_we;
  logic [CA-1:0]       ctx_waddr, ctx_raddr;
  lpr_pkg::ctx_t       ctx_wdata, ctx_rdata;

  // effective image size
  logic [16:0]   wz;
  logic [WW-1:0] w_eff;
  logic [16:0]   h_eff;
  logic [WW-1:0] col1;
  logic [16:0]   row1;
  logic          in_fire, wb_fire;

  always_comb begin
    wz = {4'b0, width_q};
    if (wz == 17'd0)                 w_eff = WW'(1);
    else if (wz > 17'(MAX_WIDTH))    w_eff = WW'(MAX_WIDTH);
    else                             w_eff = wz[WW-1:0];
    h_eff = (height_q == 16'd0) ? 17'd1 : {1'b0, height_q};
    col1  = {1'b0, col_q} + WW'(1);
    row1  = {1'b0, row_q} + 17'd1;
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign wb_fire = (state_q == StWb) && (!out_valid_q || m_axis_tready);

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      width_q  <= 13'd4096;
      height_q <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (lpr_pkg::cfg_idx_e'(cfg_idx_i))
        lpr_pkg::CfgMode:   mode_q   <= cfg_data_i[0];
        lpr_pkg::CfgWidth:  width_q  <= cfg_data_i[12:0];
        lpr_pkg::CfgHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // datapath temporaries
  logic [7:0]        d_v, a_v, c_v;
  logic signed [3:0] q1, q2, q3;
  logic              neg_v;
  logic signed [9:0] csg, pred10;
  logic [7:0]        pred8, diff8, rs8;
  logic signed [9:0] bsum0, bsh;
  logic [6:0]        nn;
  logic [9:0]        mag10;
  logic [7:0]        r8;
  logic signed [8:0] corr9;
  logic signed [9:0] bs_a, n1s;

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    left_d      = left_q;
    upleft_d    = upleft_q;
    low8_d      = low8_q;
    clr_go_d    = clr_go_q;
    clr_cnt_d   = clr_cnt_q;
    b_d         = b_q;
    med_d       = med_q;
    sgn_d       = sgn_q;
    k_d         = k_q;
    e_d         = e_q;
    pix_d       = pix_q;
    n_d         = n_q;
    bias_d      = bias_q;
    bs_d        = bs_q;
    n1_d        = n1_q;
    res_d       = res_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dcnt_d      = dcnt_q;
    neg_d       = neg_q;
    out_d       = out_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    line_we    = 1'b0;
    line_waddr = col_q;
    line_raddr = col1[CW-1:0];
    ctx_we     = 1'b0;
    ctx_waddr  = k_q;
    ctx_wdata  = lpr_pkg::CtxInit;
    ctx_raddr  = k_q;

    d_v = 8'd0; a_v = 8'd0; c_v = 8'd0;
    q1 = 4'sd0; q2 = 4'sd0; q3 = 4'sd0; neg_v = 1'b0;
    csg = 10'sd0; pred10 = 10'sd0; pred8 = 8'd0; diff8 = 8'd0; rs8 = 8'd0;
    bsum0 = 10'sd0; bsh = 10'sd0; nn = 7'd0; mag10 = 10'd0; r8 = 8'd0;
    corr9 = 9'sd0; bs_a = 10'sd0; n1s = 10'sd0;

    unique case (state_q)
      StClr: begin
        ctx_we    = 1'b1;
        ctx_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + CA'(1);
        if (clr_cnt_q == CA'(lpr_pkg::NumCtx - 1)) begin
          state_d  = clr_go_q ? StPos : StIdle;
          clr_go_d = 1'b0;
        end
      end
      StIdle: begin
        if (in_fire) begin
          low8_d = s_axis_tdata[7:0];
          if (s_axis_tuser) begin
            col_d     = '0;
            row_d     = '0;
            left_d    = '0;
            upleft_d  = '0;
            clr_cnt_d = '0;
            clr_go_d  = 1'b1;
            state_d   = StClr;
          end else begin
            state_d = StPos;
          end
        end
      end
      StPos: begin
        // wrap a position left outside the image by a register change
        if ({1'b0, col_q} >= w_eff) begin
          col_d = '0;
          row_d = (row1 >= h_eff) ? 16'd0 : row1[15:0];
        end else if ({1'b0, row_q} >= h_eff) begin
          row_d = '0;
        end
        line_raddr = col_d;
        state_d    = StRdB;
      end
      StRdB: begin
        b_d        = (row_q == 16'd0) ? 8'd0 : line_rdata;
        line_raddr = col1[CW-1:0];
        state_d    = StRdD;
      end
      StRdD: begin
        d_v = (row_q == 16'd0 || col1 >= w_eff) ? b_q : line_rdata;
        a_v = (col_q == '0) ? b_q : left_q;
        c_v = (col_q == '0) ? b_q : ((row_q == 16'd0) ? 8'd0 : upleft_q);
        q1 = lpr_pkg::quant9($signed({2'b0, d_v}) - $signed({2'b0, b_q}));
        q2 = lpr_pkg::quant9($signed({2'b0, b_q}) - $signed({2'b0, c_v}));
        q3 = lpr_pkg::quant9($signed({2'b0, c_v}) - $signed({2'b0, a_v}));
        neg_v = (q1 < 0) || (q1 == 0 && q2 < 0) || (q1 == 0 && q2 == 0 && q3 < 0);
        if (neg_v) begin
          q1 = -q1; q2 = -q2; q3 = -q3;
        end
        k_d       = lpr_pkg::ctx_index(q1, q2, q3);
        ctx_raddr = k_d;
        sgn_d     = neg_v;
        med_d     = lpr_pkg::med(a_v, b_q, c_v);
        state_d   = StCtx;
      end
      StCtx: begin
        // biased prediction, then residual or pixel
        csg    = sgn_q ? -10'(ctx_rdata.corr) : 10'(ctx_rdata.corr);
        pred10 = $signed({2'b0, med_q}) + csg;
        if (pred10 < 0)             pred8 = 8'd0;
        else if (pred10 > 10'sd255) pred8 = 8'd255;
        else                        pred8 = pred10[7:0];
        if (!mode_q) begin
          diff8 = low8_q - pred8;
          if (sgn_q) diff8 = 8'd0 - diff8;
          e_d   = $signed(diff8);
          pix_d = low8_q;
          res_d = {diff8[7], diff8};
        end else begin
          e_d   = $signed(low8_q);
          rs8   = sgn_q ? (8'd0 - low8_q) : low8_q;
          pix_d = pred8 + rs8;
          res_d = {1'b0, pix_d};
        end
        n_d     = ctx_rdata.count;
        bias_d  = ctx_rdata.bias;
        state_d = StPrep;
      end
      StPrep: begin
        bsum0 = 10'(bias_q) + 10'(e_q);
        nn    = n_q;
        bsh   = bsum0;
        if (n_q == 7'd64) begin
          bsh = (bsum0 + $signed({9'b0, bsum0[9]})) >>> 1;
          nn  = 7'd32;
        end
        n1_d  = nn + 7'd1;
        bs_d  = bsh;
        mag10 = (bsh < 0) ? 10'(-bsh) : 10'(bsh);
        mag10 = mag10 + {4'b0, n1_d[6:1]};
        quo_d  = mag10[7:0];
        rem_d  = '0;
        dcnt_d = '0;
        neg_d  = (bsh < 0);
        state_d = StDiv;
      end
      StDiv: begin
        // one quotient bit per cycle
        r8 = {rem_q, quo_q[7]};
        if (r8 >= {1'b0, n1_q}) begin
          r8    = r8 - {1'b0, n1_q};
          quo_d = {quo_q[6:0], 1'b1};
        end else begin
          quo_d = {quo_q[6:0], 1'b0};
        end
        rem_d  = r8[6:0];
        dcnt_d = dcnt_q + 3'd1;
        if (dcnt_q == 3'd7) state_d = StWb;
      end
      StWb: begin
        corr9 = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
        n1s   = $signed({3'b0, n1_q});
        bs_a  = bs_q;
        if (bs_a <= -n1s) begin
          corr9 = corr9 - 9'sd1;
          bs_a  = bs_a + n1s;
          if (bs_a <= -n1s) bs_a = 10'sd1 - n1s;
        end else if (bs_a > 0) begin
          corr9 = corr9 + 9'sd1;
          bs_a  = bs_a - n1s;
          if (bs_a > 0) bs_a = 10'sd0;
        end
        if (corr9 < -9'sd128)     corr9 = -9'sd128;
        else if (corr9 > 9'sd127) corr9 = 9'sd127;
        if (wb_fire) begin
          ctx_we          = 1'b1;
          ctx_waddr       = k_q;
          ctx_wdata.count = n1_q;
          ctx_wdata.bias  = bs_a[6:0];
          ctx_wdata.corr  = corr9[7:0];
          line_we         = 1'b1;
          line_waddr      = col_q;
          left_d          = pix_q;
          upleft_d        = b_q;
          out_valid_d     = 1'b1;
          out_d           = res_q;
          out_last_d      = (col1 >= w_eff) && (row1 >= h_eff);
          if (col1 >= w_eff) begin
            col_d = '0;
            row_d = (row1 >= h_eff) ? 16'd0 : row1[15:0];
          end else begin
            col_d = col1[CW-1:0];
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClr;
      clr_cnt_q   <= '0;
      clr_go_q    <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
      upleft_q    <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_go_q    <= clr_go_d;
      col_q       <= col_d;
      row_q       <= row_d;
      left_q      <= left_d;
      upleft_q    <= upleft_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    low8_q     <= low8_d;
    b_q        <= b_d;
    med_q      <= med_d;
    sgn_q      <= sgn_d;
    k_q        <= k_d;
    e_q        <= e_d;
    pix_q      <= pix_d;
    n_q        <= n_d;
    bias_q     <= bias_d;
    bs_q       <= bs_d;
    n1_q       <= n1_d;
    res_q      <= res_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    neg_q      <= neg_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  // previous row of pixels
  lpr_ram #(
    .Width (8),
    .Depth (MAX_WIDTH),
    .Aw    (CW)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (pix_q),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  // context store: count, bias sum, correction
  lpr_ram #(
    .Width ($bits(lpr_pkg::ctx_t)),
    .Depth (lpr_pkg::NumCtx),
    .Aw    (CA)
  ) u_ctx (
    .clk_i   (clk_i),
    .we_i    (ctx_we),
    .waddr_i (ctx_waddr),
    .wdata_i (ctx_wdata),
    .raddr_i (ctx_raddr),
    .rdata_o (ctx_rdata)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_q};
  assign m_axis_tlast  = out_last_q;

`include "loco_predictor_residual_assert.svh"

  `LPR_ASSERT(a_ctx_addr, !ctx_we || (ctx_waddr < CA'(lpr_pkg::NumCtx)), "ctx write out of range")
  `LPR_ASSERT(a_div_rem, (state_q != StDiv) || ({1'b0, rem_q} < {1'b0, n1_q}), "divider remainder")
  `LPR_ASSERT_NEXT(a_wb_out, wb_fire, m_axis_tvalid, "result not presented after write-back")

endmodule

FILE: hw/rtl/lpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned Aw    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
